>>> design/pbm_pkg.sv
// Shared types, operation codes and channel masks for the pixel blend and modulate unit.
`default_nettype none
package pbm_pkg;

   typedef logic [2:0]  cmd_type;
   typedef logic [31:0] pixel_type;
   typedef logic [8:0]  weight_type;

   localparam cmd_type CMD_BLEND32_ALPHA = 3'd0;
   localparam cmd_type CMD_BLEND32_SRC   = 3'd1;
   localparam cmd_type CMD_BLEND16_ALPHA = 3'd2;
   localparam cmd_type CMD_SELECT16      = 3'd3;
   localparam cmd_type CMD_SELECT16X2    = 3'd4;
   localparam cmd_type CMD_MUL16         = 3'd5;
   localparam cmd_type CMD_MUL32_KEEP_A  = 3'd6;
   localparam cmd_type CMD_MUL32_ALL     = 3'd7;

   localparam pixel_type RB32_MASK = 32'h00FF_00FF;
   localparam pixel_type XG32_MASK = 32'h0000_FF00;
   localparam pixel_type RB16_MASK = 32'h0000_7C1F;
   localparam pixel_type XG16_MASK = 32'h0000_03E0;

endpackage
`default_nettype wire

>>> design/pbm_lerp.sv
// Two-lane linear interpolation between a destination and a source pixel, 32-bit or 16-bit masks.
`default_nettype none
module pbm_lerp (
   input  pbm_pkg::pixel_type  pixel_d,
   input  pbm_pkg::pixel_type  pixel_s,
   input  pbm_pkg::weight_type weight,
   input  logic                is16,
   output pbm_pkg::pixel_type  blended
);
   import pbm_pkg::*;

   pixel_type mask_rb;
   pixel_type mask_xg;
   pixel_type d_rb;
   pixel_type d_xg;
   pixel_type diff_rb;
   pixel_type diff_xg;
   pixel_type prod_rb;
   pixel_type prod_xg;
   pixel_type shift_rb;
   pixel_type shift_xg;
   pixel_type sum_rb;
   pixel_type sum_xg;

   always_comb begin
      mask_rb  = is16 ? RB16_MASK : RB32_MASK;
      mask_xg  = is16 ? XG16_MASK : XG32_MASK;
      d_rb     = pixel_d & mask_rb;
      d_xg     = pixel_d & mask_xg;
      // Differences wrap modulo 2^32, as do the products.
      diff_rb  = (pixel_s & mask_rb) - d_rb;
      diff_xg  = (pixel_s & mask_xg) - d_xg;
      prod_rb  = diff_rb * {23'd0, weight};
      prod_xg  = diff_xg * {23'd0, weight};
      shift_rb = is16 ? (prod_rb >> 5) : (prod_rb >> 8);
      shift_xg = is16 ? (prod_xg >> 5) : (prod_xg >> 8);
      sum_rb   = shift_rb + d_rb;
      sum_xg   = shift_xg + d_xg;
      blended  = (sum_rb & mask_rb) | (sum_xg & mask_xg);
   end

endmodule
`default_nettype wire

>>> design/pbm_datapath.sv
// Combinational operation logic: blends, alpha selects and channel multiplies.
`default_nettype none
module pbm_datapath (
   input  pbm_pkg::cmd_type    cmd,
   input  pbm_pkg::pixel_type  pixel_a,
   input  pbm_pkg::pixel_type  pixel_b,
   input  pbm_pkg::weight_type alpha,
   output pbm_pkg::pixel_type  pixel_out
);
   import pbm_pkg::*;

   logic [7:0]  src_alpha;
   weight_type  lerp_weight;
   logic        lerp_is16;
   pixel_type   lerp_out;
   logic [15:0] sel_lo;
   logic [15:0] sel_hi;
   logic [9:0]  m16_r;
   logic [9:0]  m16_g;
   logic [9:0]  m16_b;
   logic [15:0] m32_a;
   logic [15:0] m32_r;
   logic [15:0] m32_g;
   logic [15:0] m32_b;

   assign src_alpha = pixel_b[31:24];

   always_comb begin
      lerp_is16 = (cmd == CMD_BLEND16_ALPHA);
      // Source alpha above half gets a bump of one, so the weight runs up to 256.
      if (cmd == CMD_BLEND32_SRC) begin
         lerp_weight = {1'b0, src_alpha} + {8'd0, src_alpha[7]};
      end else begin
         lerp_weight = alpha;
      end
   end

   pbm_lerp u_lerp (
      .pixel_d (pixel_a),
      .pixel_s (pixel_b),
      .weight  (lerp_weight),
      .is16    (lerp_is16),
      .blended (lerp_out)
   );

   // A set source bit 15 takes the destination's bit 15 and the source's low bits.
   always_comb begin
      sel_lo = pixel_b[15] ? {pixel_a[15], pixel_b[14:0]} : {1'b0, pixel_a[14:0]};
      sel_hi = pixel_b[31] ? {pixel_a[31], pixel_b[30:16]} : {1'b0, pixel_a[30:16]};
   end

   always_comb begin
      m16_r = {5'd0, pixel_a[14:10]} * {5'd0, pixel_b[14:10]};
      m16_g = {5'd0, pixel_a[9:5]} * {5'd0, pixel_b[9:5]};
      m16_b = {5'd0, pixel_a[4:0]} * {5'd0, pixel_b[4:0]};
      m32_a = {8'd0, pixel_a[31:24]} * {8'd0, pixel_b[31:24]};
      m32_r = {8'd0, pixel_a[23:16]} * {8'd0, pixel_b[23:16]};
      m32_g = {8'd0, pixel_a[15:8]} * {8'd0, pixel_b[15:8]};
      m32_b = {8'd0, pixel_a[7:0]} * {8'd0, pixel_b[7:0]};
   end

   always_comb begin
      unique case (cmd)
         CMD_BLEND32_ALPHA: pixel_out = lerp_out;
         CMD_BLEND32_SRC: begin
            if (src_alpha == 8'h00) begin
               pixel_out = pixel_a;
            end else if (src_alpha == 8'hFF) begin
               pixel_out = pixel_b;
            end else begin
               pixel_out = {src_alpha, lerp_out[23:0]};
            end
         end
         CMD_BLEND16_ALPHA: pixel_out = {16'd0, lerp_out[15:0]};
         CMD_SELECT16:      pixel_out = {16'd0, sel_lo};
         CMD_SELECT16X2:    pixel_out = {sel_hi, sel_lo};
         CMD_MUL16: begin
            pixel_out = {16'd0, pixel_a[15] & pixel_b[15], m16_r[9:5], m16_g[9:5],
                         m16_b[9:5]};
         end
         CMD_MUL32_KEEP_A: begin
            pixel_out = {pixel_a[31:24], m32_r[15:8], m32_g[15:8], m32_b[15:8]};
         end
         default: begin
            pixel_out = {m32_a[15:8], m32_r[15:8], m32_g[15:8], m32_b[15:8]};
         end
      endcase
   end

endmodule
`default_nettype wire

>>> design/pixel_blend_modulate_unit.sv
// A request is captured in the input register; the datapath works on it combinationally
// and the result register holds its result for the response outputs.
// Throughput: one request per cycle; the input and result registers form a
// two-stage pipeline that advances whenever the result side is not stalled.
// The result register parts the channels, so one more request is taken while a result waits.
// Reset clears both stage valid bits; data registers are not reset.
`default_nettype none
module pixel_blend_modulate_unit (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  pbm_pkg::cmd_type    req_cmd,
   input  pbm_pkg::pixel_type  req_pixel_a,
   input  pbm_pkg::pixel_type  req_pixel_b,
   input  pbm_pkg::weight_type req_alpha,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output pbm_pkg::pixel_type  rsp_pixel_out
);
   import pbm_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   cmd_type    in_cmd_ff;
   pixel_type  in_pixel_a_ff;
   pixel_type  in_pixel_b_ff;
   weight_type in_alpha_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   pixel_type  out_pixel_ff;
   pixel_type  out_pixel_in;
   logic       out_load;
   logic       in_load;

   pbm_datapath u_datapath (
      .cmd       (in_cmd_ff),
      .pixel_a   (in_pixel_a_ff),
      .pixel_b   (in_pixel_b_ff),
      .alpha     (in_alpha_ff),
      .pixel_out (out_pixel_in)
   );

   always_comb begin
      out_load     = !out_valid_ff || !rsp_stall;
      in_load      = !in_valid_ff || out_load;
      req_stall    = !in_load;
      in_valid_in  = in_load ? req_valid : in_valid_ff;
      out_valid_in = out_load ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_cmd_ff     <= req_cmd;
         in_pixel_a_ff <= req_pixel_a;
         in_pixel_b_ff <= req_pixel_b;
         in_alpha_ff   <= req_alpha;
      end
      if (out_load && in_valid_ff) begin
         out_pixel_ff <= out_pixel_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;

endmodule
`default_nettype wire

>>> tb/sv/tb_pixel_blend_modulate_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the pixel blend and modulate unit, with a scoreboard class.
module tb_pixel_blend_modulate_unit;
   import pbm_pkg::*;

   localparam int        RANDOM_REQUESTS  = 1900;
   localparam int        LONG_HOLD_CYCLES = 300;
   localparam int        IDLE_LIMIT       = 4000;
   localparam pixel_type ALPHA32_MASK     = 32'hFF00_0000;
   localparam pixel_type LOW16_MASK       = 32'h0000_FFFF;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_pattern_type;

   class blend_scoreboard;
      pixel_type expected_pixels[$];
      int        mismatches = 0;

      static function pixel_type lerp_channels(pixel_type d, pixel_type s, pixel_type w,
                                               pixel_type m_rb, pixel_type m_xg,
                                               int unsigned sh);
         pixel_type d_rb, d_xg, rb, xg;
         d_rb = d & m_rb;
         d_xg = d & m_xg;
         rb   = (s & m_rb) - d_rb;
         xg   = (s & m_xg) - d_xg;
         rb   = rb * w;
         xg   = xg * w;
         rb   = (rb >> sh) + d_rb;
         xg   = (xg >> sh) + d_xg;
         return (rb & m_rb) | (xg & m_xg);
      endfunction

      static function pixel_type multiply_rgb(pixel_type a, pixel_type b);
         pixel_type r, g, bl;
         r  = ((a & 32'h00FF_0000) >> 12) * ((b & 32'h00FF_0000) >> 12);
         g  = (a & 32'h0000_FF00) * (b & 32'h0000_FF00);
         bl = (a & 32'h0000_00FF) * (b & 32'h0000_00FF);
         return (r & 32'h00FF_0000) | ((g >> 16) & 32'h0000_FF00) | ((bl >> 8) & 32'h0000_00FF);
      endfunction

      static function pixel_type combine_pixel(cmd_type cmd, pixel_type a, pixel_type b,
                                               weight_type w);
         pixel_type w32, m, sa, r, a16, b16;
         w32 = {23'd0, w};
         a16 = a & LOW16_MASK;
         b16 = b & LOW16_MASK;
         case (cmd)
            CMD_BLEND32_ALPHA: r = lerp_channels(a, b, w32, RB32_MASK, XG32_MASK, 8);
            CMD_BLEND32_SRC: begin
               sa = b & ALPHA32_MASK;
               if (sa == 32'd0) begin
                  r = a;
               end else if (sa == ALPHA32_MASK) begin
                  r = b;
               end else begin
                  // Weights above one half get bumped by one so that 254 lands near full.
                  sa = sa >> 24;
                  sa = sa + (sa >> 7);
                  r  = (b & ALPHA32_MASK) | lerp_channels(a, b, sa, RB32_MASK, XG32_MASK, 8);
               end
            end
            CMD_BLEND16_ALPHA: begin
               r = lerp_channels(a16, b, w32, RB16_MASK, XG16_MASK, 5) & LOW16_MASK;
            end
            CMD_SELECT16: begin
               m = ((b16 & 32'h0000_8000) >> 15) + 32'h0000_7FFF;
               r = ((a16 & m) | (b16 & ~m)) & LOW16_MASK;
            end
            CMD_SELECT16X2: begin
               m = ((b & 32'h8000_8000) >> 15) + 32'h7FFF_7FFF;
               r = (a & m) | (b & ~m);
            end
            CMD_MUL16: begin
               m = (a16 & 32'h0000_7C00) * (b16 & 32'h0000_7C00);
               r = (m & 32'h3E00_0000) >> 15;
               m = (a16 & 32'h0000_03E0) * (b16 & 32'h0000_03E0);
               r = r | ((m & 32'h000F_8000) >> 10);
               m = (a16 & 32'h0000_001F) * (b16 & 32'h0000_001F);
               r = r | ((m & 32'h0000_03E0) >> 5);
               r = r | (a16 & b16 & 32'h0000_8000);
            end
            CMD_MUL32_KEEP_A: r = (a & ALPHA32_MASK) | multiply_rgb(a, b);
            default: begin
               m = ((a & ALPHA32_MASK) >> 16) * ((b & ALPHA32_MASK) >> 16);
               r = (m & ALPHA32_MASK) | multiply_rgb(a, b);
            end
         endcase
         return r;
      endfunction

      function void note_request(cmd_type cmd, pixel_type a, pixel_type b, weight_type w);
         expected_pixels.push_back(combine_pixel(cmd, a, b, w));
      endfunction

      function void check_result(pixel_type actual);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: result %h arrived with no request outstanding", $time, actual);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            if (actual !== want) begin
               $display("%0t: pixel_out mismatch, expected %h, actual %h", $time, want, actual);
               mismatches++;
            end
         end
      endfunction

      function int outstanding();
         return expected_pixels.size();
      endfunction
   endclass

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   cmd_type    req_cmd       = CMD_BLEND32_ALPHA;
   pixel_type  req_pixel_a   = '0;
   pixel_type  req_pixel_b   = '0;
   weight_type req_alpha     = '0;
   logic       rsp_stall     = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   pixel_type  rsp_pixel_out;

   blend_scoreboard sb;
   bit              hold_pending = 1'b0;

   pixel_blend_modulate_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_pixel_a   (req_pixel_a),
      .req_pixel_b   (req_pixel_b),
      .req_alpha     (req_alpha),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_cmd, req_pixel_a, req_pixel_b, req_alpha);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_pixel_out);
         end
      end
   end

   task automatic send_request(cmd_type c, pixel_type a, pixel_type b, weight_type w);
      req_valid   <= 1'b1;
      req_cmd     <= c;
      req_pixel_a <= a;
      req_pixel_b <= b;
      req_alpha   <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pause_sender(int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      pause_sender(1);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   function automatic pixel_type random_pixel();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_request();
      cmd_type    c;
      pixel_type  a, b;
      weight_type w;
      c = cmd_type'($urandom_range(0, 7));
      a = random_pixel();
      b = random_pixel();
      w = weight_type'($urandom_range(0, 511));
      case (c)
         CMD_BLEND32_ALPHA: begin
            if ($urandom_range(0, 7) != 0) w = weight_type'($urandom_range(0, 256));
         end
         CMD_BLEND16_ALPHA: begin
            if ($urandom_range(0, 7) != 0) w = weight_type'($urandom_range(0, 32));
         end
         CMD_BLEND32_SRC: begin
            // Push the source alpha onto its shortcut values now and then.
            case ($urandom_range(0, 3))
               0:       b[31:24] = 8'h00;
               1:       b[31:24] = 8'hFF;
               default: ;
            endcase
         end
         default: ;
      endcase
      send_request(c, a, b, w);
   endtask

   task automatic run_directed();
      send_request(CMD_BLEND32_ALPHA, 32'h0000_0000, 32'hFFFF_FFFF, 9'd0);
      send_request(CMD_BLEND32_ALPHA, 32'h0000_0000, 32'hFFFF_FFFF, 9'd256);
      send_request(CMD_BLEND32_ALPHA, 32'hFFFF_FFFF, 32'h0000_0000, 9'd256);
      send_request(CMD_BLEND32_ALPHA, 32'h1234_5678, 32'hFEDC_BA98, 9'd128);
      send_request(CMD_BLEND32_ALPHA, 32'h1234_5678, 32'hFEDC_BA98, 9'd257);
      send_request(CMD_BLEND32_ALPHA, 32'hFEDC_BA98, 32'h1234_5678, 9'd511);
      send_request(CMD_BLEND32_SRC,   32'h89AB_CDEF, 32'h0012_3456, 9'd0);
      send_request(CMD_BLEND32_SRC,   32'h89AB_CDEF, 32'hFF12_3456, 9'd0);
      send_request(CMD_BLEND32_SRC,   32'h89AB_CDEF, 32'h8012_3456, 9'd0);
      send_request(CMD_BLEND32_SRC,   32'h89AB_CDEF, 32'h7F12_3456, 9'd0);
      send_request(CMD_BLEND32_SRC,   32'hFFFF_FFFF, 32'h01FE_DCBA, 9'd511);
      send_request(CMD_BLEND16_ALPHA, 32'h0000_0000, 32'hFFFF_FFFF, 9'd0);
      send_request(CMD_BLEND16_ALPHA, 32'h0000_0000, 32'hFFFF_FFFF, 9'd32);
      send_request(CMD_BLEND16_ALPHA, 32'hABCD_1234, 32'h5678_FEDC, 9'd33);
      send_request(CMD_BLEND16_ALPHA, 32'hFFFF_FFFF, 32'h0000_0000, 9'd511);
      send_request(CMD_SELECT16,      32'hFFFF_7ABC, 32'h1234_8123, 9'd0);
      send_request(CMD_SELECT16,      32'hFFFF_FABC, 32'hFFFF_7123, 9'd0);
      send_request(CMD_SELECT16X2,    32'h8000_1234, 32'h1234_8000, 9'd0);
      send_request(CMD_SELECT16X2,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd511);
      send_request(CMD_MUL16,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd0);
      send_request(CMD_MUL16,         32'h1234_ABCD, 32'h5678_9EF1, 9'd511);
      send_request(CMD_MUL32_KEEP_A,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd0);
      send_request(CMD_MUL32_KEEP_A,  32'h89AB_CDEF, 32'h0123_4567, 9'd0);
      send_request(CMD_MUL32_ALL,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd0);
      send_request(CMD_MUL32_ALL,     32'h89AB_CDEF, 32'h7654_3210, 9'd0);
   endtask

   // Result side: random stall patterns, plus one long hold when the sender asks for it.
   initial begin
      stall_pattern_type pattern;
      int                span;
      int                i;
      @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            pattern = stall_pattern_type'($urandom_range(0, 3));
            span    = $urandom_range(5, 60);
            for (i = 0; i < span && !hold_pending; i++) begin
               case (pattern)
                  STALL_NONE:  rsp_stall <= 1'b0;
                  STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                  STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default:     rsp_stall <= ~rsp_stall;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int sent;
      int burst;
      bit hold_done;
      bit mid_drain_done;
      sb             = new();
      sent           = 0;
      hold_done      = 1'b0;
      mid_drain_done = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      drain_results();
      while (sent < RANDOM_REQUESTS) begin
         if (!hold_done && sent >= RANDOM_REQUESTS / 3) begin
            // Keep offering requests back to back while the result side holds off.
            hold_done    = 1'b1;
            hold_pending = 1'b1;
            repeat (60) send_random_request();
            sent += 60;
         end
         if (!mid_drain_done && sent >= (2 * RANDOM_REQUESTS) / 3) begin
            mid_drain_done = 1'b1;
            drain_results();
         end
         burst = $urandom_range(1, 40);
         repeat (burst) send_random_request();
         sent += burst;
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
      end
      drain_results();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
design/pbm_pkg.sv
design/pbm_lerp.sv
design/pbm_datapath.sv
design/pixel_blend_modulate_unit.sv
tb/sv/tb_pixel_blend_modulate_unit.sv
